@@ rtl/ipt_pkg.sv @@
// Shared types and constants for the impulse priority table.
// Payload structs, stored entry layout, command/action/register codes.
// No dependencies.
package ipt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int SLOT_W              = 4;
  localparam int CFG_IDX_W           = 3;

  // Q16.16 filter limits
  localparam logic signed [31:0] STR_FLOOR_HI = 32'sd655;
  localparam logic signed [31:0] STR_FLOOR_LO = -32'sd655;
  localparam logic signed [32:0] HEIGHT_ABOVE = 33'sd196608;
  localparam logic signed [32:0] HEIGHT_BELOW = -33'sd262144;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_REJECT      = 3'd0,
    ACT_APPEND      = 3'd1,
    ACT_NEARER      = 3'd2,
    ACT_WEAKEST     = 3'd3,
    ACT_DROP        = 3'd4,
    ACT_FLUSHED     = 3'd5,
    ACT_FLUSH_EMPTY = 3'd6
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SURFACE_Y    = 3'd0,
    REG_BOX_MIN_X    = 3'd1,
    REG_BOX_MAX_X    = 3'd2,
    REG_BOX_MIN_Z    = 3'd3,
    REG_BOX_MAX_Z    = 3'd4,
    REG_CENTER_X     = 3'd5,
    REG_CENTER_Z     = 3'd6,
    REG_WAKE_ENABLED = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] strength;
  } req_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic signed [31:0] entry_z;
    logic signed [31:0] entry_strength;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] s;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic is_new;
    logic kill;
  } pipe_ctl_t;

  typedef struct packed {
    logic        valid;
    logic        is_new;
    logic [64:0] dsq;
    logic [31:0] str;
  } dist_res_t;

endpackage

@@ rtl/impulse_priority_table.sv @@
// Impulse priority table, top level.
//
// Channels: req (req_valid/req_stall/req) carries one command per transaction,
// an add of one impulse or a flush. rsp (rsp_valid/rsp_stall/rsp) returns
// results; every add gives one result with last set, a flush gives one result
// per stored entry in slot order (last on the final one), or a single
// flush-empty result. cfg (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// registers; cfg_ready is always high and writes belong in idle periods.
// Timing: one command at a time; req_stall is high until the command's final
// result is loaded into the output register. An add that finds room or is
// rejected goes through ST_CHECK and ST_RESULT. An add to a full table streams
// stored entries through the one-read-per-cycle memory port and the three-stage
// distance pipe, stopping early at an entry that it replaces as nearer. A flush
// loads one result per cycle in ST_FLUSH unless rsp stalls. A stall on rsp
// holds the output register and, when the next result is ready, holds the
// sequencer; the next command can be taken while the last result waits. Reset
// (synchronous) empties the table and clears state, rsp_valid, pipe valids
// and config; table contents are not cleared and are never read before written.
// Depends on ipt_pkg, ipt_store, ipt_dist_pipe.
module impulse_priority_table import ipt_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_RESULT,
    ST_FLUSH
  } state_t;

  state_t state;

  // configuration
  logic signed [31:0] surface_y, box_min_x, box_max_x, box_min_z, box_max_z;
  logic signed [31:0] center_x, center_z;
  logic               wake_enabled;

  // pending command and sequencer state
  entry_t        item;
  logic          item_flush;
  logic [CW-1:0] count;
  logic [CW-1:0] iss_cnt;
  logic [AW-1:0] fl_idx;
  logic [64:0]   dnew;
  logic [31:0]   istr;
  logic [32:0]   min_str;
  logic [AW-1:0] min_idx;
  logic [2:0]    res_action;
  logic [AW-1:0] res_slot;

  // datapath
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        rd_data;
  pipe_ctl_t     pipe_ctl;
  dist_res_t     pres;
  logic [AW-1:0] pres_idx;

  logic               out_free, rsp_load, full, reject, fl_last;
  logic signed [32:0] y_rel;
  logic               c_entry, hit, scan_last, weak_win, min_upd;
  logic [32:0]        min_str_next;
  logic [AW-1:0]      min_idx_next;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = ((state == ST_RESULT) || (state == ST_FLUSH)) && out_free;
  assign full      = (count == CW'(TABLE_DEPTH));
  assign fl_last   = (CW'(fl_idx) == (count - CW'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_y    <= '0;
      box_min_x    <= '0;
      box_max_x    <= '0;
      box_min_z    <= '0;
      box_max_z    <= '0;
      center_x     <= '0;
      center_z     <= '0;
      wake_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SURFACE_Y:    surface_y    <= cfg_data;
        REG_BOX_MIN_X:    box_min_x    <= cfg_data;
        REG_BOX_MAX_X:    box_max_x    <= cfg_data;
        REG_BOX_MIN_Z:    box_min_z    <= cfg_data;
        REG_BOX_MAX_Z:    box_max_z    <= cfg_data;
        REG_CENTER_X:     center_x     <= cfg_data;
        REG_CENTER_Z:     center_z     <= cfg_data;
        REG_WAKE_ENABLED: wake_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // add filter, evaluated on the registered command
  always_comb begin
    y_rel  = $signed({item.y[31], item.y}) - $signed({surface_y[31], surface_y});
    reject = !wake_enabled
          || (($signed(item.s) >= STR_FLOOR_LO) && ($signed(item.s) <= STR_FLOOR_HI))
          || (y_rel > HEIGHT_ABOVE) || (y_rel < HEIGHT_BELOW)
          || ($signed(item.x) < box_min_x) || ($signed(item.x) > box_max_x)
          || ($signed(item.z) < box_min_z) || ($signed(item.z) > box_max_z);
  end

  // replacement search over the pipe output; new impulse leads the entries
  always_comb begin
    c_entry      = (state == ST_SCAN) && pres.valid && !pres.is_new;
    hit          = c_entry && (dnew < pres.dsq) && (istr >= pres.str);
    scan_last    = c_entry && (pres_idx == AW'(TABLE_DEPTH - 1));
    min_upd      = c_entry && (min_str > {1'b0, pres.str});
    min_str_next = min_upd ? {1'b0, pres.str} : min_str;
    min_idx_next = min_upd ? pres_idx : min_idx;
    weak_win     = (min_str_next < {1'b0, istr});
  end

  // memory and pipe control; a scan write never targets the slot being read
  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;
    pipe_ctl.valid  = 1'b0;
    pipe_ctl.is_new = 1'b0;
    pipe_ctl.kill   = 1'b0;
    case (state)
      ST_CHECK: begin
        if (item_flush) begin
          rd_en = (count != '0);
        end else if (!reject && !full) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
        end else if (!reject) begin
          pipe_ctl.valid  = 1'b1;
          pipe_ctl.is_new = 1'b1;
        end
      end
      ST_SCAN: begin
        rd_en          = (iss_cnt < CW'(TABLE_DEPTH));
        rd_addr        = iss_cnt[AW-1:0];
        pipe_ctl.valid = rd_en;
        pipe_ctl.kill  = hit || scan_last;
        if (hit) begin
          wr_en   = 1'b1;
          wr_addr = pres_idx;
        end else if (scan_last && weak_win) begin
          wr_en   = 1'b1;
          wr_addr = min_idx_next;
        end
      end
      ST_FLUSH: begin
        rd_en   = out_free && !fl_last;
        rd_addr = fl_idx + AW'(1);
      end
      default: ;
    endcase
  end

  ipt_store #(.DEPTH(TABLE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (item),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ipt_dist_pipe #(.DEPTH(TABLE_DEPTH)) u_dist (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pipe_ctl),
    .in_idx   (rd_addr),
    .item     (item),
    .rd_data  (rd_data),
    .center_x (center_x),
    .center_z (center_z),
    .res      (pres),
    .res_idx  (pres_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            item.x     <= req.pos_x;
            item.y     <= req.pos_y;
            item.z     <= req.pos_z;
            item.s     <= req.strength;
            item_flush <= (req.command == CMD_FLUSH);
            state      <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (item_flush) begin
            if (count == '0) begin
              res_action <= ACT_FLUSH_EMPTY;
              res_slot   <= '0;
              state      <= ST_RESULT;
            end else begin
              fl_idx <= '0;
              state  <= ST_FLUSH;
            end
          end else if (reject) begin
            res_action <= ACT_REJECT;
            res_slot   <= '0;
            state      <= ST_RESULT;
          end else if (!full) begin
            res_action <= ACT_APPEND;
            res_slot   <= count[AW-1:0];
            count      <= count + CW'(1);
            state      <= ST_RESULT;
          end else begin
            iss_cnt <= '0;
            min_str <= '1;
            min_idx <= '0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            iss_cnt <= iss_cnt + CW'(1);
          end
          if (pres.valid && pres.is_new) begin
            dnew <= pres.dsq;
            istr <= pres.str;
          end
          if (c_entry) begin
            min_str <= min_str_next;
            min_idx <= min_idx_next;
          end
          if (hit) begin
            res_action <= ACT_NEARER;
            res_slot   <= pres_idx;
            state      <= ST_RESULT;
          end else if (scan_last) begin
            res_action <= weak_win ? ACT_WEAKEST : ACT_DROP;
            res_slot   <= weak_win ? min_idx_next : '0;
            state      <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            rsp.action         <= res_action;
            rsp.slot           <= SLOT_W'(res_slot);
            rsp.entry_x        <= '0;
            rsp.entry_y        <= '0;
            rsp.entry_z        <= '0;
            rsp.entry_strength <= '0;
            rsp.last           <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            rsp.action         <= ACT_FLUSHED;
            rsp.slot           <= SLOT_W'(fl_idx);
            rsp.entry_x        <= rd_data.x;
            rsp.entry_y        <= rd_data.y;
            rsp.entry_z        <= rd_data.z;
            rsp.entry_strength <= rd_data.s;
            rsp.last           <= fl_last;
            if (fl_last) begin
              count <= '0;
              state <= ST_IDLE;
            end else begin
              fl_idx <= fl_idx + AW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ipt_store.sv @@
// Impulse entry memory: one write port, one read port, registered read data.
// Depends on ipt_pkg (entry_t).
module ipt_store import ipt_pkg::*; #(
  parameter int  DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ipt_dist_pipe.sv @@
// Three-stage distance/strength pipe: |dx|,|dz|,|s| -> squares -> squared distance.
// Takes either the pending impulse or the memory read data.
// Depends on ipt_pkg.
module ipt_dist_pipe import ipt_pkg::*; #(
  parameter int  DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  pipe_ctl_t          ctl,
  input  logic [AW-1:0]      in_idx,
  input  entry_t             item,
  input  entry_t             rd_data,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_z,
  output dist_res_t          res,
  output logic [AW-1:0]      res_idx
);

  logic          a_valid, a_new;
  logic [AW-1:0] a_idx;
  logic          b_valid, b_new;
  logic [AW-1:0] b_idx;
  logic [31:0]   b_ax, b_az, b_es;
  logic          c_valid, c_new;
  logic [AW-1:0] c_idx;
  logic [63:0]   c_pa, c_pb;
  logic [31:0]   c_es;

  entry_t             src;
  logic signed [32:0] dx, dz, dx_neg, dz_neg;
  logic [31:0]        ax, az, es, s_neg;
  logic [63:0]        pa, pb;

  // stage A: memory data arrives here in the cycle after the read
  always_comb begin
    src    = a_new ? item : rd_data;
    dx     = $signed({center_x[31], center_x}) - $signed({src.x[31], src.x});
    dz     = $signed({center_z[31], center_z}) - $signed({src.z[31], src.z});
    dx_neg = -dx;
    dz_neg = -dz;
    ax     = dx[32] ? dx_neg[31:0] : dx[31:0];
    az     = dz[32] ? dz_neg[31:0] : dz[31:0];
    s_neg  = ~src.s + 32'd1;
    es     = src.s[31] ? s_neg : src.s;
  end

  assign pa = b_ax * b_ax;
  assign pb = b_az * b_az;

  always_ff @(posedge clk) begin
    if (rst || ctl.kill) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= ctl.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
    a_new <= ctl.is_new;
    a_idx <= in_idx;
    b_new <= a_new;
    b_idx <= a_idx;
    b_ax  <= ax;
    b_az  <= az;
    b_es  <= es;
    c_new <= b_new;
    c_idx <= b_idx;
    c_pa  <= pa;
    c_pb  <= pb;
    c_es  <= b_es;
  end

  assign res.valid  = c_valid;
  assign res.is_new = c_new;
  assign res.dsq    = {1'b0, c_pa} + {1'b0, c_pb};
  assign res.str    = c_es;
  assign res_idx    = c_idx;

endmodule

@@ rtl/ipt_checker.sv @@
// Port-level checks for impulse_priority_table, attached by bind.
// Depends on ipt_pkg (rsp_t, action codes).
module ipt_checker import ipt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a waiting result is neither lost nor altered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed or dropped while stalled");

  // add commands give one result with no entry data
  a_add_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.action == ACT_REJECT || rsp.action == ACT_APPEND ||
                  rsp.action == ACT_NEARER || rsp.action == ACT_WEAKEST ||
                  rsp.action == ACT_DROP)
    |-> rsp.last && rsp.entry_x == '0 && rsp.entry_y == '0 &&
        rsp.entry_z == '0 && rsp.entry_strength == '0)
    else $error("add result not single or carries entry data");

  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.action == ACT_FLUSH_EMPTY |-> rsp.slot == '0 && rsp.last)
    else $error("flush-empty result malformed");

  // one command in flight: an accepted transaction blocks the next cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second command accepted back to back");

endmodule

bind impulse_priority_table ipt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

@@ verif/testbench.sv @@
// Self-checking testbench for impulse_priority_table: directed filter, extreme and
// replacement cases, then random region setups with random idling on both channels.
// Depends on ipt_pkg and the impulse_priority_table RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipt_pkg::*;

  localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int ONE_Q = 65536;
  localparam int BOX_Q = 16 * ONE_Q;
  localparam int Q_MAX = 32'sh7fff_ffff;
  localparam int Q_MIN = 32'sh8000_0000;
  localparam longint STR_FLOOR = 655;
  localparam longint ABOVE_Q = 196608;
  localparam longint BELOW_Q = 262144;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // predictor state
  logic [31:0] reg_val [8] = '{default: '0};
  entry_t impulse_tab [TABLE_DEPTH];
  int live_count = 0;
  rsp_t pending_results [$];

  int unsigned req_gap_max = 5;
  int unsigned rsp_stall_max = 5;
  int unsigned hold_left = 0;
  bit narrow_str = 1'b0;
  int unsigned fail_count = 0;
  int unsigned cmds_sent = 0;
  int unsigned results_seen = 0;
  int unsigned act_seen [7] = '{default: 0};

  always #6 clk = ~clk;

  impulse_priority_table u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  function automatic longint reg_s(cfg_reg_e idx);
    return longint'($signed(reg_val[idx]));
  endfunction

  function automatic logic [32:0] str_mag(logic signed [31:0] s);
    longint v;
    v = longint'(s);
    return 33'((v < 0) ? -v : v);
  endfunction

  // exact squared x/z distance to the region centre
  function automatic logic [65:0] center_dist(logic signed [31:0] x, logic signed [31:0] z);
    longint dx, dz;
    logic [65:0] ax, az;
    dx = reg_s(REG_CENTER_X) - longint'(x);
    dz = reg_s(REG_CENTER_Z) - longint'(z);
    ax = 66'((dx < 0) ? -dx : dx);
    az = 66'((dz < 0) ? -dz : dz);
    return ax * ax + az * az;
  endfunction

  function automatic void queue_result(rsp_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  task automatic apply_command(req_t it);
    rsp_t r;
    entry_t fresh;
    longint px, py, pz, ps, water;
    logic [65:0] new_dist;
    logic [32:0] new_mag, min_mag, cur_mag;
    int i, min_slot;
    bit placed;
    r = '0;
    r.last = 1'b1;
    px = longint'(it.pos_x);
    py = longint'(it.pos_y);
    pz = longint'(it.pos_z);
    ps = longint'(it.strength);
    water = reg_s(REG_SURFACE_Y);
    fresh = {it.pos_x, it.pos_y, it.pos_z, it.strength};
    if (it.command == CMD_FLUSH) begin
      if (live_count == 0) begin
        r.action = ACT_FLUSH_EMPTY;
        queue_result(r);
      end else begin
        for (i = 0; i < live_count; i++) begin
          r.action = ACT_FLUSHED;
          r.slot = SLOT_W'(i);
          r.entry_x = impulse_tab[i].x;
          r.entry_y = impulse_tab[i].y;
          r.entry_z = impulse_tab[i].z;
          r.entry_strength = impulse_tab[i].s;
          r.last = (i == live_count - 1);
          queue_result(r);
        end
        live_count = 0;
      end
      return;
    end
    if (!reg_val[REG_WAKE_ENABLED][0] || (ps >= -STR_FLOOR && ps <= STR_FLOOR) ||
        py - water > ABOVE_Q || py < water - BELOW_Q ||
        px < reg_s(REG_BOX_MIN_X) || px > reg_s(REG_BOX_MAX_X) ||
        pz < reg_s(REG_BOX_MIN_Z) || pz > reg_s(REG_BOX_MAX_Z)) begin
      r.action = ACT_REJECT;
    end else if (live_count < TABLE_DEPTH) begin
      impulse_tab[live_count] = fresh;
      r.action = ACT_APPEND;
      r.slot = SLOT_W'(live_count);
      live_count++;
    end else begin
      new_mag = str_mag(it.strength);
      new_dist = center_dist(it.pos_x, it.pos_z);
      min_mag = '1;
      min_slot = 0;
      placed = 1'b0;
      // first farther, no-stronger entry wins; track weakest (lowest slot on ties)
      for (i = 0; i < TABLE_DEPTH && !placed; i++) begin
        cur_mag = str_mag(impulse_tab[i].s);
        if (new_dist < center_dist(impulse_tab[i].x, impulse_tab[i].z) &&
            new_mag >= cur_mag) begin
          impulse_tab[i] = fresh;
          r.action = ACT_NEARER;
          r.slot = SLOT_W'(i);
          placed = 1'b1;
        end else if (cur_mag < min_mag) begin
          min_mag = cur_mag;
          min_slot = i;
        end
      end
      if (!placed) begin
        if (min_mag < new_mag) begin
          impulse_tab[min_slot] = fresh;
          r.action = ACT_WEAKEST;
          r.slot = SLOT_W'(min_slot);
        end else begin
          r.action = ACT_DROP;
        end
      end
    end
    queue_result(r);
  endtask

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (rsp.action <= ACT_FLUSH_EMPTY) act_seen[rsp.action]++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual action %0d slot %0d",
                 $time, rsp.action, rsp.slot);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        note_mismatch("action", want.action, rsp.action);
        note_mismatch("slot", want.slot, rsp.slot);
        note_mismatch("entry_x", want.entry_x, rsp.entry_x);
        note_mismatch("entry_y", want.entry_y, rsp.entry_y);
        note_mismatch("entry_z", want.entry_z, rsp.entry_z);
        note_mismatch("entry_strength", want.entry_strength, rsp.entry_strength);
        note_mismatch("last", want.last, rsp.last);
      end
    end
  end

  // receiver backpressure: random hold after each accepted result
  always @(posedge clk) begin
    int unsigned draw;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
    end else if (rsp_valid && !rsp_stall) begin
      draw = $urandom_range(0, rsp_stall_max);
      hold_left <= draw;
      rsp_stall <= (draw != 0);
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= (hold_left > 1);
    end
  end

  task automatic send_cmd(req_t it);
    int unsigned gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!(req_valid && !req_stall));
    apply_command(it);
    cmds_sent++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    reg_val[idx] = val;
  endtask

  // registers change only once every outstanding result has drained
  task automatic program_region(int water, int min_x, int max_x, int min_z, int max_z,
                                int cx, int cz, logic wake);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    write_reg(REG_SURFACE_Y, water);
    write_reg(REG_BOX_MIN_X, min_x);
    write_reg(REG_BOX_MAX_X, max_x);
    write_reg(REG_BOX_MIN_Z, min_z);
    write_reg(REG_BOX_MAX_Z, max_z);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_WAKE_ENABLED, {31'd0, wake});
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t make_add(int x, int y, int z, int s);
    req_t it;
    it.command = CMD_ADD;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.strength = s;
    return it;
  endfunction

  function automatic req_t flush_cmd();
    req_t it;
    it = make_add($urandom(), $urandom(), $urandom(), $urandom());
    it.command = CMD_FLUSH;
    return it;
  endfunction

  function automatic int rand_between(longint lo, longint hi);
    longint unsigned span, r;
    if (hi <= lo) return int'(lo);
    span = hi - lo + 1;
    r = {$urandom(), $urandom()};
    return int'(lo + longint'(r % span));
  endfunction

  function automatic int random_strength();
    longint m;
    if (narrow_str) begin
      m = longint'($urandom_range(656, 660));
    end else begin
      case ($urandom_range(0, 3))
        0: m = longint'($urandom_range(656, 2000));
        3: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
        default: m = longint'(rand_between(656, Q_MAX));
      endcase
    end
    return $urandom_range(0, 1) ? int'(m) : int'(-m);
  endfunction

  // mostly well-formed adds, some near misses on one filter, some noise, few flushes
  function automatic req_t random_cmd();
    req_t it;
    int pick;
    longint water, lo_x, hi_x, lo_z, hi_z;
    pick = $urandom_range(0, 99);
    if (pick < 5) return flush_cmd();
    if (pick < 15) return make_add($urandom(), $urandom(), $urandom(), $urandom());
    water = reg_s(REG_SURFACE_Y);
    lo_x = reg_s(REG_BOX_MIN_X);
    hi_x = reg_s(REG_BOX_MAX_X);
    lo_z = reg_s(REG_BOX_MIN_Z);
    hi_z = reg_s(REG_BOX_MAX_Z);
    it = make_add(rand_between(lo_x, hi_x),
                  rand_between((water - BELOW_Q < Q_MIN) ? Q_MIN : water - BELOW_Q,
                               (water + ABOVE_Q > Q_MAX) ? Q_MAX : water + ABOVE_Q),
                  rand_between(lo_z, hi_z), random_strength());
    if (pick < 25) begin
      case ($urandom_range(0, 3))
        0: it.strength = rand_between(-STR_FLOOR, STR_FLOOR);
        1: begin
          if (water + ABOVE_Q < Q_MAX &&
              (water - BELOW_Q <= Q_MIN || $urandom_range(0, 1) != 0))
            it.pos_y = 32'(water + ABOVE_Q + 1);
          else
            it.pos_y = 32'(water - BELOW_Q - 1);
        end
        2: begin
          if (hi_x < Q_MAX) it.pos_x = 32'(hi_x + 1);
          else if (lo_x > Q_MIN) it.pos_x = 32'(lo_x - 1);
        end
        default: begin
          if (lo_z > Q_MIN) it.pos_z = 32'(lo_z - 1);
          else if (hi_z < Q_MAX) it.pos_z = 32'(hi_z + 1);
        end
      endcase
    end
    return it;
  endfunction

  // registers at reset: disabled, so a perfectly centred add is still rejected
  task automatic test_disabled_defaults();
    send_cmd(make_add(0, 0, 0, ONE_Q));
    send_cmd(flush_cmd());
  endtask

  // height window at the register extremes (no wrap) and an inverted box
  task automatic test_height_and_box_extremes();
    program_region(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0, 0, 1'b1);
    send_cmd(make_add(0, Q_MIN, 0, ONE_Q));
    send_cmd(make_add(0, Q_MAX, 0, ONE_Q));
    program_region(Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0, 0, 1'b1);
    send_cmd(make_add(0, Q_MAX, 0, ONE_Q));
    program_region(0, 1, 0, Q_MIN, Q_MAX, 0, 0, 1'b1);
    send_cmd(make_add(0, 0, 0, ONE_Q));
    send_cmd(flush_cmd());
  endtask

  // each filter just outside and just inside its limit, then fill the table
  task automatic test_filter_edges();
    int k;
    program_region(0, -BOX_Q, BOX_Q, -BOX_Q, BOX_Q, 0, 0, 1'b1);
    send_cmd(make_add(0, 0, 0, 655));
    send_cmd(make_add(0, 0, 0, -655));
    send_cmd(make_add(0, 196609, 0, ONE_Q));
    send_cmd(make_add(0, -262145, 0, ONE_Q));
    send_cmd(make_add(BOX_Q + 1, 0, 0, ONE_Q));
    send_cmd(make_add(0, 0, -BOX_Q - 1, ONE_Q));
    send_cmd(make_add(-BOX_Q, 196608, BOX_Q, 656));
    send_cmd(make_add(BOX_Q, -262144, -BOX_Q, -656));
    send_cmd(make_add(3 * ONE_Q, 0, ONE_Q, Q_MAX));
    send_cmd(make_add(-2 * ONE_Q, ONE_Q, 5 * ONE_Q, Q_MIN));
    for (k = 1; k <= 12; k++)
      send_cmd(make_add(k * ONE_Q, k * 8192 - 50000, -k * 32768,
                        (k % 2 != 0) ? 1000 + 777 * k : -(1000 + 777 * k)));
  endtask

  // full table: weakest with a tie, weakest again, drop on equal strength, nearer
  task automatic test_full_table_priority();
    send_cmd(make_add(BOX_Q, 0, BOX_Q, 700));
    send_cmd(make_add(-BOX_Q, 0, -BOX_Q, 700));
    send_cmd(make_add(BOX_Q, 0, -BOX_Q, -700));
    send_cmd(make_add(0, 0, 0, 800));
    send_cmd(flush_cmd());
  endtask

  task automatic random_region(int style);
    int a, b, c, d;
    narrow_str = 1'b0;
    req_gap_max = 5;
    rsp_stall_max = 5;
    case (style)
      0: program_region(0, -BOX_Q, BOX_Q, -BOX_Q, BOX_Q, 0, 0, 1'b1);
      1: begin
        // back-to-back traffic, centre in a corner for the widest distances
        req_gap_max = 0;
        rsp_stall_max = 0;
        program_region($urandom(), Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                       $urandom_range(0, 1) ? Q_MAX : Q_MIN,
                       $urandom_range(0, 1) ? Q_MIN : Q_MAX, 1'b1);
      end
      2: begin
        // tiny box and narrow strengths to force distance and strength ties
        narrow_str = 1'b1;
        a = rand_between(-1000000000, 1000000000);
        b = rand_between(-1000000000, 1000000000);
        program_region($urandom(), a, a + 3, b, b + 3, a + 1, b + 2, 1'b1);
      end
      3: begin
        a = $urandom();
        b = $urandom();
        c = $urandom();
        d = $urandom();
        if (a > b && $urandom_range(0, 3) != 0) {a, b} = {b, a};
        if (c > d && $urandom_range(0, 3) != 0) {c, d} = {d, c};
        program_region($urandom(), a, b, c, d, $urandom(), $urandom(),
                       $urandom_range(0, 3) != 0);
      end
      default: begin
        req_gap_max = 2;
        program_region($urandom_range(0, 1) ? Q_MAX : Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                       0, 0, 1'b1);
      end
    endcase
  endtask

  task automatic test_random_traffic();
    int style, n;
    for (style = 0; style < 5; style++) begin
      random_region(style);
      for (n = 0; n < 43; n++) send_cmd(random_cmd());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_disabled_defaults();
    test_height_and_box_extremes();
    test_filter_edges();
    test_full_table_priority();
    test_random_traffic();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Summary: %0d commands, %0d results checked over directed and 5 random setups",
             cmds_sent, results_seen);
    $display("  reject %0d, append %0d, nearer %0d, weakest %0d, drop %0d, flushed %0d, empty %0d",
             act_seen[ACT_REJECT], act_seen[ACT_APPEND], act_seen[ACT_NEARER],
             act_seen[ACT_WEAKEST], act_seen[ACT_DROP], act_seen[ACT_FLUSHED],
             act_seen[ACT_FLUSH_EMPTY]);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
